[design/prrts_pkg.sv]
`default_nettype none
package prrts_pkg;
    localparam int NUM_TASKS_DEF = 32;
    localparam int NUM_LEVELS_DEF = 8;
    localparam int MAX_LOCK_DEPTH_DEF = 15;

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_SELECT = 3'd2;
    localparam logic [2:0] MODE_BOOST = 3'd3;
    localparam logic [2:0] MODE_RESTORE = 3'd4;
    localparam logic [2:0] MODE_LOCK = 3'd5;
    localparam logic [2:0] MODE_UNLOCK = 3'd6;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_LOCK_ERR = 2'd3;

    // command as it travels through the queue
    typedef struct packed {
        logic [2:0] mode;
        logic [4:0] task_id;
        logic [2:0] priority_req;
    } cmd_t;

    // result of one command
    typedef struct packed {
        logic [1:0] status;
        logic [4:0] chosen_task;
        logic [2:0] highest_priority;
        logic       any_ready;
    } rsp_t;
endpackage
`default_nettype wire

[design/prrts_cmd_fifo.sv]
`default_nettype none
module prrts_cmd_fifo (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  prrts_pkg::cmd_t  in_cmd,
    output logic             out_valid,
    input  wire              out_ready,
    output prrts_pkg::cmd_t  out_cmd
);
    // two entry queue between front and back
    prrts_pkg::cmd_t slot_reg [2];
    logic            rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic            push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) slot_reg[wr_ptr_reg] <= in_cmd;
    end
endmodule
`default_nettype wire

[design/prrts_front.sv]
`default_nettype none
module prrts_front #(
    parameter int NUM_TASKS  = prrts_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS = prrts_pkg::NUM_LEVELS_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              s_valid,
    output logic             s_ready,
    input  wire [10:0]       s_data,
    output logic             q_valid,
    input  wire              q_ready,
    output prrts_pkg::cmd_t  q_cmd
);
    // input register: unpacks the beat, saturates level, marks bad ids
    logic            full_reg;
    prrts_pkg::cmd_t cmd_reg, cmd_next;
    logic [2:0]      lv;

    always_comb begin
        lv = s_data[10:8];
        if ({29'd0, lv} > 32'(NUM_LEVELS - 1)) lv = 3'(NUM_LEVELS - 1);
        cmd_next.mode         = s_data[2:0];
        cmd_next.task_id      = s_data[7:3];
        cmd_next.priority_req = lv;
        // out of range ids become unknown mode for id commands
        if ({27'd0, s_data[7:3]} >= 32'(NUM_TASKS) &&
            (s_data[2:0] == prrts_pkg::MODE_ADD || s_data[2:0] == prrts_pkg::MODE_REMOVE ||
             s_data[2:0] == prrts_pkg::MODE_BOOST ||
             s_data[2:0] == prrts_pkg::MODE_RESTORE))
            cmd_next.mode = 3'b111;
    end

    assign s_ready = !full_reg || q_ready;
    assign q_valid = full_reg;
    assign q_cmd   = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_reg <= 1'b0;
        end else if (s_ready) begin
            full_reg <= s_valid;
        end
        if (s_valid && s_ready) cmd_reg <= cmd_next;
    end
endmodule
`default_nettype wire

[design/prrts_back.sv]
`default_nettype none
module prrts_back #(
    parameter int NUM_TASKS      = prrts_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS     = prrts_pkg::NUM_LEVELS_DEF,
    parameter int MAX_LOCK_DEPTH = prrts_pkg::MAX_LOCK_DEPTH_DEF
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              c_valid,
    output logic             c_ready,
    input  prrts_pkg::cmd_t  c_cmd,
    output logic             r_valid,
    input  wire              r_ready,
    output prrts_pkg::rsp_t  r_rsp
);
    localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int DW = $clog2(MAX_LOCK_DEPTH + 1);
    localparam int CW = $clog2(NUM_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_UNLINK, S_LINK, S_DROP, S_DRAIN, S_RESP
    } state_t;

    // link memories and per-task state
    logic [TW-1:0] next_mem [NUM_TASKS];
    logic [TW-1:0] prev_mem [NUM_TASKS];
    logic [LW-1:0] lvl_mem  [NUM_TASKS];
    logic [TW-1:0] pend_mem [NUM_TASKS];
    logic [TW-1:0] head_reg [NUM_LEVELS];
    logic [TW-1:0] tail_reg [NUM_LEVELS];
    logic [NUM_LEVELS-1:0] nonempty_reg;
    logic [NUM_TASKS-1:0]  queued_reg, pending_reg;
    logic [CW-1:0] pcnt_reg, rd_idx_reg, wr_idx_reg;
    logic [DW-1:0] depth_reg;

    state_t          state_reg;
    prrts_pkg::cmd_t cmd_reg;
    logic [TW-1:0]   t_reg;
    logic [LW-1:0]   nlv_reg;
    logic            relink_reg;
    logic [1:0]      st_reg;
    logic [4:0]      chosen_reg;
    logic            rv_reg;
    logic [2:0]      hi_reg;
    logic            any_reg;

    logic [TW-1:0] tt;
    logic [LW-1:0] cur_lv, sel_lv, hi_lv;
    logic          sel_found;
    logic [TW-1:0] pf_cur;

    assign tt     = cmd_reg.task_id[TW-1:0];
    assign cur_lv = lvl_mem[t_reg];
    assign pf_cur = pend_mem[rd_idx_reg[TW-1:0]];

    // most urgent level of the select, and after the command
    always_comb begin
        sel_found = 1'b0;
        sel_lv    = LW'(NUM_LEVELS - 1);
        for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                sel_found = 1'b1;
                sel_lv    = LW'(i);
            end
        end
        hi_lv = sel_lv;
    end

    assign c_ready = (state_reg == S_IDLE) && !rv_reg;
    assign r_valid = rv_reg;
    assign r_rsp   = '{status: st_reg, chosen_task: chosen_reg,
                       highest_priority: hi_reg, any_ready: any_reg};

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nonempty_reg <= '0;
            queued_reg   <= '0;
            pending_reg  <= '0;
            pcnt_reg     <= '0;
            depth_reg    <= '0;
            rv_reg       <= 1'b0;
        end else begin
            if (rv_reg && r_ready) rv_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (c_valid && c_ready) begin
                        cmd_reg    <= c_cmd;
                        t_reg      <= c_cmd.task_id[TW-1:0];
                        nlv_reg    <= c_cmd.priority_req[LW-1:0];
                        st_reg     <= prrts_pkg::ST_DONE;
                        chosen_reg <= '0;
                        relink_reg <= 1'b0;
                        state_reg  <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    state_reg <= S_RESP;
                    unique case (cmd_reg.mode) inside
                        prrts_pkg::MODE_ADD: begin
                            if (queued_reg[tt] || pending_reg[tt]) begin
                                st_reg <= prrts_pkg::ST_IGNORED;
                            end else begin
                                lvl_mem[tt] <= nlv_reg;
                                if (depth_reg != '0) begin
                                    pending_reg[tt] <= 1'b1;
                                    if (pcnt_reg < CW'(NUM_TASKS)) begin
                                        pend_mem[pcnt_reg[TW-1:0]] <= tt;
                                        pcnt_reg <= pcnt_reg + 1'b1;
                                    end
                                end else begin
                                    state_reg <= S_LINK;
                                end
                            end
                        end
                        prrts_pkg::MODE_REMOVE: begin
                            if (!queued_reg[tt] && !pending_reg[tt]) begin
                                st_reg <= prrts_pkg::ST_IGNORED;
                            end else if (queued_reg[tt]) begin
                                state_reg <= S_UNLINK;
                            end else begin
                                rd_idx_reg <= '0;
                                wr_idx_reg <= '0;
                                state_reg  <= S_DROP;
                            end
                        end
                        prrts_pkg::MODE_SELECT: begin
                            if (!sel_found) begin
                                st_reg <= prrts_pkg::ST_EMPTY;
                            end else begin
                                chosen_reg <= 5'(head_reg[sel_lv]);
                                t_reg      <= head_reg[sel_lv];
                                nlv_reg    <= sel_lv;
                                if (tail_reg[sel_lv] != head_reg[sel_lv]) begin
                                    relink_reg <= 1'b1;
                                    state_reg  <= S_UNLINK;
                                end
                            end
                        end
                        prrts_pkg::MODE_BOOST, prrts_pkg::MODE_RESTORE: begin
                            if ((cmd_reg.mode == prrts_pkg::MODE_RESTORE ||
                                 nlv_reg < cur_lv) && nlv_reg != cur_lv) begin
                                if (queued_reg[tt]) begin
                                    relink_reg <= 1'b1;
                                    state_reg  <= S_UNLINK;
                                end else begin
                                    lvl_mem[tt] <= nlv_reg;
                                end
                            end
                        end
                        prrts_pkg::MODE_LOCK: begin
                            if (32'(depth_reg) >= 32'(MAX_LOCK_DEPTH))
                                st_reg <= prrts_pkg::ST_LOCK_ERR;
                            else
                                depth_reg <= depth_reg + 1'b1;
                        end
                        prrts_pkg::MODE_UNLOCK: begin
                            if (depth_reg == '0) begin
                                st_reg <= prrts_pkg::ST_LOCK_ERR;
                            end else begin
                                depth_reg <= depth_reg - 1'b1;
                                if (depth_reg == DW'(1)) begin
                                    rd_idx_reg <= '0;
                                    state_reg  <= S_DRAIN;
                                end
                            end
                        end
                        default: st_reg <= prrts_pkg::ST_IGNORED;
                    endcase
                end
                // take t_reg out of its level
                S_UNLINK: begin
                    queued_reg[t_reg] <= 1'b0;
                    if (head_reg[cur_lv] == t_reg && tail_reg[cur_lv] == t_reg) begin
                        nonempty_reg[cur_lv] <= 1'b0;
                    end else if (head_reg[cur_lv] == t_reg) begin
                        head_reg[cur_lv] <= next_mem[t_reg];
                    end else if (tail_reg[cur_lv] == t_reg) begin
                        tail_reg[cur_lv] <= prev_mem[t_reg];
                    end else begin
                        next_mem[prev_mem[t_reg]] <= next_mem[t_reg];
                        prev_mem[next_mem[t_reg]] <= prev_mem[t_reg];
                    end
                    if (relink_reg) begin
                        lvl_mem[t_reg] <= nlv_reg;
                        state_reg      <= S_LINK;
                    end else if (pending_reg[t_reg]) begin
                        rd_idx_reg <= '0;
                        wr_idx_reg <= '0;
                        state_reg  <= S_DROP;
                    end else begin
                        state_reg <= S_RESP;
                    end
                end
                // append t_reg at the tail of its level
                S_LINK: begin
                    queued_reg[t_reg] <= 1'b1;
                    if (nonempty_reg[cur_lv]) begin
                        next_mem[tail_reg[cur_lv]] <= t_reg;
                        prev_mem[t_reg]            <= tail_reg[cur_lv];
                    end else begin
                        head_reg[cur_lv]     <= t_reg;
                        nonempty_reg[cur_lv] <= 1'b1;
                    end
                    tail_reg[cur_lv] <= t_reg;
                    if (cmd_reg.mode == prrts_pkg::MODE_UNLOCK) begin
                        pending_reg[t_reg] <= 1'b0;
                        rd_idx_reg         <= rd_idx_reg + 1'b1;
                        state_reg          <= S_DRAIN;
                    end else begin
                        state_reg <= S_RESP;
                    end
                end
                // compact the pending fifo, one entry a cycle
                S_DROP: begin
                    if (rd_idx_reg >= pcnt_reg) begin
                        pcnt_reg           <= wr_idx_reg;
                        pending_reg[t_reg] <= 1'b0;
                        state_reg          <= S_RESP;
                    end else begin
                        if (pf_cur != t_reg) begin
                            pend_mem[wr_idx_reg[TW-1:0]] <= pf_cur;
                            wr_idx_reg <= wr_idx_reg + 1'b1;
                        end
                        rd_idx_reg <= rd_idx_reg + 1'b1;
                    end
                end
                // move pending tasks into their levels, one at a time through S_LINK
                S_DRAIN: begin
                    if (rd_idx_reg >= pcnt_reg) begin
                        pcnt_reg  <= '0;
                        state_reg <= S_RESP;
                    end else begin
                        t_reg     <= pf_cur;
                        state_reg <= S_LINK;
                    end
                end
                S_RESP: begin
                    hi_reg    <= 3'(hi_lv);
                    any_reg   <= sel_found;
                    rv_reg    <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

[design/priority_round_robin_task_scheduler.sv]
// Priority round-robin task scheduler.
// s_axis: one command per beat, tdata = mode[2:0], task_id[7:3], priority_req[10:8].
// m_axis: one result per command, tdata = status[1:0], chosen_task[6:2],
//   highest_priority[9:7], any_ready[10].
// A front register takes and checks the command, a two-entry queue feeds the
// back sequencer, which updates the linked ready lists held in memories.
// Lock, unlock without drain, ignored commands and a select or priority change
// that moves nothing go from decode straight to the response; an add while
// unlocked and the remove of a queued task pass a link or unlink step, a select
// that rotates and a priority change that relinks pass both. Removing a pending
// task also walks the pending list; the last unlock links each pending task in
// turn. The single sequencer takes no new command until its result is taken.
// Reset clears all level and task flags and the lock count; links are
// rewritten before they are read. A stalled m_axis holds the result, the
// sequencer waits, and the queue and front register keep taking commands
// until they fill.
`default_nettype none
module priority_round_robin_task_scheduler #(
    parameter int NUM_TASKS      = prrts_pkg::NUM_TASKS_DEF,
    parameter int NUM_LEVELS     = prrts_pkg::NUM_LEVELS_DEF,
    parameter int MAX_LOCK_DEPTH = prrts_pkg::MAX_LOCK_DEPTH_DEF
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [15:0]  s_axis_tdata,  // mode, task_id, priority_req
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata   // status, chosen_task, highest_priority, any_ready
);
    logic            fq_valid, fq_ready, qb_valid, qb_ready;
    prrts_pkg::cmd_t fq_cmd, qb_cmd;
    prrts_pkg::rsp_t rsp;

    prrts_front #(.NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
        .s_data(s_axis_tdata[10:0]),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
    );

    prrts_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_cmd(fq_cmd),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_cmd(qb_cmd)
    );

    prrts_back #(
        .NUM_TASKS(NUM_TASKS), .NUM_LEVELS(NUM_LEVELS), .MAX_LOCK_DEPTH(MAX_LOCK_DEPTH)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .c_valid(qb_valid), .c_ready(qb_ready), .c_cmd(qb_cmd),
        .r_valid(m_axis_tvalid), .r_ready(m_axis_tready), .r_rsp(rsp)
    );

    assign m_axis_tdata = {5'd0, rsp.any_ready, rsp.highest_priority,
                           rsp.chosen_task, rsp.status};
endmodule
`default_nettype wire

[design/prrts_checker.sv]
`default_nettype none
module prrts_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata
);
    // result beat holds while stalled
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
    // any_ready agrees with highest_priority
    a_any: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tdata[10] |-> m_axis_tdata[9:7] == 3'd7)
        else $error("idle result names a level");
    // chosen task is zero on every command whose status is not done
    a_chosen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[1:0] != 2'd0 |-> m_axis_tdata[6:2] == 5'd0)
        else $error("chosen task on failed command");
    // no result right after reset
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result out of reset");
endmodule

bind priority_round_robin_task_scheduler prrts_checker u_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
module tb;
    localparam int N_TASKS    = prrts_pkg::NUM_TASKS_DEF;
    localparam int N_LEVELS   = prrts_pkg::NUM_LEVELS_DEF;
    localparam int LOCK_MAX   = prrts_pkg::MAX_LOCK_DEPTH_DEF;
    localparam int RAND_CMDS  = 390;
    localparam int QUIET_FROM = 340;
    localparam int HOLD_LEN   = 80;
    localparam int STALL_LIM  = 3000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [15:0] m_axis_tdata;

    priority_round_robin_task_scheduler u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),  // mode, task_id, priority_req
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)   // status, chosen_task, highest_priority, any_ready
    );

    always #4 aclk = ~aclk;

    // shadow copy of the ready lists
    logic [4:0] nxt_link [N_TASKS];
    logic [4:0] prv_link [N_TASKS];
    logic [4:0] lvl_head [N_LEVELS];
    logic [4:0] lvl_tail [N_LEVELS];
    logic [2:0] task_lvl [N_TASKS];
    logic [N_LEVELS-1:0] lvl_busy;
    logic [N_TASKS-1:0]  in_queue, is_ready, in_pending, lvl_known;
    logic [4:0] pend_list [$];
    int         lock_cnt;

    prrts_pkg::rsp_t expected_rsp [$];
    int   err_cnt = 0;
    bit   idle_on = 1'b1;
    bit   hold_req = 1'b0;
    int   rand_done = 0;

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        err_cnt++;
    endtask

    function automatic void append_task(input logic [4:0] t);
        logic [2:0] lv;
        lv = task_lvl[t];
        if (lvl_busy[lv]) begin
            nxt_link[lvl_tail[lv]] = t;
            prv_link[t] = lvl_tail[lv];
        end else begin
            lvl_head[lv] = t;
            lvl_busy[lv] = 1'b1;
        end
        lvl_tail[lv] = t;
        in_queue[t] = 1'b1;
    endfunction

    function automatic void detach_task(input logic [4:0] t);
        logic [2:0] lv;
        lv = task_lvl[t];
        if (lvl_head[lv] == t && lvl_tail[lv] == t) lvl_busy[lv] = 1'b0;
        else if (lvl_head[lv] == t) lvl_head[lv] = nxt_link[t];
        else if (lvl_tail[lv] == t) lvl_tail[lv] = prv_link[t];
        else begin
            nxt_link[prv_link[t]] = nxt_link[t];
            prv_link[nxt_link[t]] = prv_link[t];
        end
        in_queue[t] = 1'b0;
    endfunction

    function automatic void move_level(input logic [4:0] t, input logic [2:0] lv);
        if (lv == task_lvl[t]) return;
        if (in_queue[t]) begin
            detach_task(t);
            task_lvl[t] = lv;
            append_task(t);
        end else begin
            task_lvl[t] = lv;
        end
    endfunction

    // next scheduler answer for one command, updating the shadow state
    function automatic prrts_pkg::rsp_t sched_response(input prrts_pkg::cmd_t c);
        prrts_pkg::rsp_t r;
        logic [4:0] h;
        r = '{status: prrts_pkg::ST_DONE, chosen_task: 5'd0,
              highest_priority: 3'(N_LEVELS - 1), any_ready: 1'b0};
        case (c.mode)
            prrts_pkg::MODE_ADD: begin
                if (in_queue[c.task_id] || in_pending[c.task_id])
                    r.status = prrts_pkg::ST_IGNORED;
                else begin
                    task_lvl[c.task_id] = c.priority_req;
                    lvl_known[c.task_id] = 1'b1;
                    if (lock_cnt > 0) begin
                        pend_list.push_back(c.task_id);
                        in_pending[c.task_id] = 1'b1;
                    end else begin
                        is_ready[c.task_id] = 1'b1;
                        append_task(c.task_id);
                    end
                end
            end
            prrts_pkg::MODE_REMOVE: begin
                if (!in_queue[c.task_id] && !in_pending[c.task_id])
                    r.status = prrts_pkg::ST_IGNORED;
                else begin
                    if (in_queue[c.task_id]) detach_task(c.task_id);
                    if (in_pending[c.task_id]) begin
                        for (int i = pend_list.size() - 1; i >= 0; i--)
                            if (pend_list[i] == c.task_id) pend_list.delete(i);
                        in_pending[c.task_id] = 1'b0;
                    end
                    is_ready[c.task_id] = 1'b0;
                end
            end
            prrts_pkg::MODE_SELECT: begin
                r.status = prrts_pkg::ST_EMPTY;
                for (int i = 0; i < N_LEVELS; i++) begin
                    if (lvl_busy[i]) begin
                        h = lvl_head[i];
                        r.chosen_task = h;
                        r.status = prrts_pkg::ST_DONE;
                        if (lvl_tail[i] != h) begin
                            detach_task(h);
                            append_task(h);
                        end
                        break;
                    end
                end
            end
            prrts_pkg::MODE_BOOST: if (c.priority_req < task_lvl[c.task_id])
                move_level(c.task_id, c.priority_req);
            prrts_pkg::MODE_RESTORE: move_level(c.task_id, c.priority_req);
            prrts_pkg::MODE_LOCK: begin
                if (lock_cnt >= LOCK_MAX) r.status = prrts_pkg::ST_LOCK_ERR;
                else lock_cnt++;
            end
            prrts_pkg::MODE_UNLOCK: begin
                if (lock_cnt == 0) r.status = prrts_pkg::ST_LOCK_ERR;
                else begin
                    if (lock_cnt == 1) begin
                        foreach (pend_list[i]) begin
                            in_pending[pend_list[i]] = 1'b0;
                            is_ready[pend_list[i]] = 1'b1;
                            append_task(pend_list[i]);
                        end
                        pend_list.delete();
                    end
                    lock_cnt--;
                end
            end
            default: r.status = prrts_pkg::ST_IGNORED;
        endcase
        for (int i = 0; i < N_LEVELS; i++) begin
            if (lvl_busy[i]) begin
                r.highest_priority = 3'(i);
                r.any_ready = 1'b1;
                break;
            end
        end
        return r;
    endfunction

    // drive one command beat and record what it should produce
    task automatic send_cmd(input prrts_pkg::cmd_t c, input bit typed,
                            input prrts_pkg::rsp_t want);
        prrts_pkg::rsp_t p;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, c.priority_req, c.task_id, c.mode};
        do @(posedge aclk); while (!s_axis_tready);
        p = sched_response(c);
        expected_rsp.push_back(typed ? want : p);
        @(negedge aclk);
    endtask

    function automatic prrts_pkg::cmd_t make_cmd(input logic [2:0] m, input int t,
                                                 input int pr);
        prrts_pkg::cmd_t c;
        c.mode = m;
        c.task_id = 5'(t);
        c.priority_req = 3'(pr);
        return c;
    endfunction

    // random command, biased toward useful traffic
    function automatic prrts_pkg::cmd_t random_cmd();
        prrts_pkg::cmd_t c;
        int   pick;
        int   known [$];
        pick = $urandom_range(0, 99);
        c = make_cmd(prrts_pkg::MODE_ADD, $urandom_range(0, N_TASKS - 1),
                     $urandom_range(0, 7));
        if (pick < 30) c.mode = prrts_pkg::MODE_ADD;
        else if (pick < 42) c.mode = prrts_pkg::MODE_REMOVE;
        else if (pick < 62) c.mode = prrts_pkg::MODE_SELECT;
        else if (pick < 82) begin
            for (int i = 0; i < N_TASKS; i++) if (lvl_known[i]) known.push_back(i);
            if (known.size() > 0) begin
                c.mode = (pick < 72) ? prrts_pkg::MODE_BOOST : prrts_pkg::MODE_RESTORE;
                c.task_id = 5'(known[$urandom_range(0, known.size() - 1)]);
            end
        end
        else if (pick < 89) c.mode = prrts_pkg::MODE_LOCK;
        else if (pick < 97) c.mode = prrts_pkg::MODE_UNLOCK;
        else c.mode = 3'd7;
        return c;
    endfunction

    // directed stimulus: mode, task, level, typed flag, expected answer
    typedef struct {
        logic [2:0]      m;
        int              t;
        int              pr;
        bit              typed;
        prrts_pkg::rsp_t want;
    } step_t;

    step_t directed [] = '{
        '{prrts_pkg::MODE_SELECT,  0, 0, 1, '{prrts_pkg::ST_EMPTY,    5'd0,  3'd7, 1'b0}},
        '{prrts_pkg::MODE_UNLOCK,  0, 0, 1, '{prrts_pkg::ST_LOCK_ERR, 5'd0,  3'd7, 1'b0}},
        '{prrts_pkg::MODE_REMOVE,  5, 0, 1, '{prrts_pkg::ST_IGNORED,  5'd0,  3'd7, 1'b0}},
        '{prrts_pkg::MODE_ADD,     0, 7, 1, '{prrts_pkg::ST_DONE,     5'd0,  3'd7, 1'b1}},
        '{prrts_pkg::MODE_ADD,    31, 0, 1, '{prrts_pkg::ST_DONE,     5'd0,  3'd0, 1'b1}},
        '{prrts_pkg::MODE_ADD,    31, 3, 1, '{prrts_pkg::ST_IGNORED,  5'd0,  3'd0, 1'b1}},
        '{prrts_pkg::MODE_SELECT,  0, 0, 1, '{prrts_pkg::ST_DONE,     5'd31, 3'd0, 1'b1}},
        '{prrts_pkg::MODE_ADD,    10, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_ADD,    11, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_SELECT,  0, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_REMOVE, 10, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_BOOST,   0, 7, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_BOOST,   0, 2, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_RESTORE, 0, 2, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_RESTORE,31, 5, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{3'd7,                   21, 5, 1, '{prrts_pkg::ST_IGNORED,  5'd0,  3'd0, 1'b1}},
        '{prrts_pkg::MODE_LOCK,    0, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_ADD,     4, 1, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_ADD,     5, 6, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_ADD,     6, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_REMOVE,  4, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_RESTORE, 5, 1, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_UNLOCK,  0, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}},
        '{prrts_pkg::MODE_SELECT,  0, 0, 0, '{prrts_pkg::ST_DONE, 0, 0, 0}}
    };

    // stimulus
    initial begin
        lvl_busy = '0; in_queue = '0; is_ready = '0; in_pending = '0; lvl_known = '0;
        lock_cnt = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i])
            send_cmd(make_cmd(directed[i].m, directed[i].t, directed[i].pr),
                     directed[i].typed, directed[i].want);
        // lock nesting past the limit, then unwind past zero
        for (int i = 0; i <= LOCK_MAX; i++) begin
            send_cmd(make_cmd(prrts_pkg::MODE_LOCK, 0, 0), 0, '0);
            if (i % 4 == 0) send_cmd(random_cmd(), 0, '0);
        end
        for (int i = 0; i <= LOCK_MAX; i++)
            send_cmd(make_cmd(prrts_pkg::MODE_UNLOCK, 0, 0), 0, '0);
        for (rand_done = 0; rand_done < RAND_CMDS; rand_done++) begin
            if (rand_done == 100) hold_req = 1'b1;
            if (rand_done == 220) begin
                s_axis_tvalid <= 1'b0;
                wait (expected_rsp.size() == 0);
                @(negedge aclk);
            end
            if (rand_done == QUIET_FROM) idle_on = 1'b0;
            send_cmd(random_cmd(), 0, '0);
        end
        s_axis_tvalid <= 1'b0;
        wait (expected_rsp.size() == 0);
        repeat (20) @(posedge aclk);
        if (err_cnt == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

    // result side ready, with short stalls and one long hold
    initial begin
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_LEN) @(negedge aclk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin
        prrts_pkg::rsp_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_rsp.size() == 0) begin
                report("unexpected beat", m_axis_tdata, 0);
            end else begin
                w = expected_rsp.pop_front();
                if (m_axis_tdata[1:0] != w.status)
                    report("status", m_axis_tdata[1:0], w.status);
                if (m_axis_tdata[6:2] != w.chosen_task)
                    report("chosen_task", m_axis_tdata[6:2], w.chosen_task);
                if (m_axis_tdata[9:7] != w.highest_priority)
                    report("highest_priority", m_axis_tdata[9:7], w.highest_priority);
                if (m_axis_tdata[10] != w.any_ready)
                    report("any_ready", m_axis_tdata[10], w.any_ready);
            end
        end
    end

    // watchdog on cycles with no beat moving
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIM) begin
            $display("Verification failed");
            $finish;
        end
    end
endmodule
